// ----- sv/lodc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lodc_pkg
// Shared widths, codes and control/status bundles for the lock-order checker.
// ----------------------------------------------------------------------------
package lodc_pkg;

  localparam int LOCK_COUNT_DEF  = 16;
  localparam int STACK_DEPTH_DEF = 32;

  // fixed word field widths
  localparam int LID_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_MULTI_UNLOCK   = 3'd1,
    ST_INVALID_UNLOCK = 3'd2,
    ST_DEADLOCK       = 3'd3,
    ST_STACK_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic    take_in;
    logic    row_walk;
    logic    push;
    logic    pop;
    logic    set_fault;
    status_t fault_code;
    logic    edge_set;
    logic    walk_init;
    logic    walk_pass;
    logic    walk_run;
    logic    out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic in_range;
    logic frozen;
    logic empty;
    logic full;
    logic top_match;
    logic edge_known;
    logic found;
    logic pass_done;
    logic changed;
  } dp_stat_t;

endpackage

// ----- sv/lodc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lodc_in_if
// Request channel: one acquire/release word per handshake.
// ----------------------------------------------------------------------------
interface lodc_in_if import lodc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [LID_W-1:0] lock_id;

  modport source (output valid, output operation, output lock_id, input ready);
  modport sink   (input valid, input operation, input lock_id, output ready);
endinterface

// ----- sv/lodc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lodc_out_if
// Result channel: status and held count, one word per request.
// ----------------------------------------------------------------------------
interface lodc_out_if import lodc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  held_count;

  modport source (output valid, output status, output held_count, input ready);
  modport sink   (input valid, input status, input held_count, output ready);
endinterface

// ----- sv/lodc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lodc_datapath
// Held-lock stack, edge matrix with row valid bits, reachability scan,
// sticky fault and the result register.
// ----------------------------------------------------------------------------
module lodc_datapath import lodc_pkg::*; #(
  parameter int LOCK_COUNT  = LOCK_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_operation,
  input  logic [LID_W-1:0]    in_lock_id,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [STATUS_W-1:0] res_status,
  output logic [COUNT_W-1:0]  res_held_count
);

  localparam int IDW = $clog2(LOCK_COUNT);
  localparam int SCW = $clog2(LOCK_COUNT + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);

  op_t                   op_r;
  logic [LID_W-1:0]      id_r;
  logic [DW-1:0]         depth_r, depth_nxt;
  status_t               fault_r, fault_nxt;
  logic [LID_W-1:0]      top_r;
  logic [LID_W-1:0]      stack_mem [STACK_DEPTH];

  logic [LOCK_COUNT-1:0] edge_mem [LOCK_COUNT];
  logic [LOCK_COUNT-1:0] edge_vld_r;
  logic [LOCK_COUNT-1:0] row_r;
  logic [IDW-1:0]        row_idx_r;

  logic [SCW-1:0]        scan_r;
  logic                  pipe_v_r;
  logic [LOCK_COUNT-1:0] reach_r, reach_upd;
  logic                  changed_r;

  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [IDW-1:0]        id_idx, top_idx, row_addr;
  logic [LOCK_COUNT-1:0] id_bit;
  logic                  consume;
  logic                  scan_more;

  assign id_idx   = IDW'(id_r);
  assign top_idx  = IDW'(top_r);
  assign row_addr = cmd.row_walk ? IDW'(scan_r) : top_idx;
  assign id_bit   = LOCK_COUNT'(1) << id_idx;

  // input word
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_r <= op_t'(in_operation);
      id_r <= in_lock_id;
    end
  end

  // held-lock stack; top is re-read every cycle at depth-1
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[SAW'(depth_r)] <= id_r;
    end
    top_r <= stack_mem[SAW'(depth_r - DW'(1))];
  end

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (cmd.pop) begin
      depth_nxt = depth_r - DW'(1);
    end
    fault_nxt = cmd.set_fault ? cmd.fault_code : fault_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      fault_r <= ST_OK;
    end else begin
      depth_r <= depth_nxt;
      fault_r <= fault_nxt;
    end
  end

  // edge matrix: rows never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.edge_set) begin
      edge_mem[top_idx] <= row_r | id_bit;
    end
    row_r     <= edge_vld_r[row_addr] ? edge_mem[row_addr] : '0;
    row_idx_r <= row_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_vld_r <= '0;
    end else if (cmd.edge_set) begin
      edge_vld_r[top_idx] <= 1'b1;
    end
  end

  // reachability from the new lock: row scan, repeated until nothing changes
  assign scan_more = scan_r < SCW'(LOCK_COUNT);
  assign consume   = cmd.walk_run && pipe_v_r && reach_r[row_idx_r];
  assign reach_upd = consume ? (reach_r | row_r) : reach_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r    <= '0;
      pipe_v_r  <= 1'b0;
      reach_r   <= '0;
      changed_r <= 1'b0;
    end else if (cmd.walk_init) begin
      scan_r    <= '0;
      pipe_v_r  <= 1'b0;
      reach_r   <= id_bit;
      changed_r <= 1'b0;
    end else if (cmd.walk_pass) begin
      scan_r    <= '0;
      pipe_v_r  <= 1'b0;
      changed_r <= 1'b0;
    end else if (cmd.walk_run) begin
      reach_r   <= reach_upd;
      changed_r <= changed_r | (reach_upd != reach_r);
      pipe_v_r  <= scan_more;
      if (scan_more) begin
        scan_r <= scan_r + SCW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= fault_r;
      out_count_r  <= COUNT_W'(depth_r);
    end
  end

  assign res_status     = out_status_r;
  assign res_held_count = out_count_r;

  always_comb begin
    stat.op         = op_r;
    stat.in_range   = 32'(id_r) < 32'(LOCK_COUNT);
    stat.frozen     = fault_r != ST_OK;
    stat.empty      = depth_r == '0;
    stat.full       = depth_r == DW'(STACK_DEPTH);
    stat.top_match  = top_r == id_r;
    stat.edge_known = row_r[id_idx];
    stat.found      = reach_r[top_idx];
    stat.pass_done  = !scan_more && !pipe_v_r;
    stat.changed    = changed_r;
  end

endmodule

// ----- sv/lodc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lodc_ctrl
// Sequencer: decodes each request, runs the cycle search, hands off results.
// ----------------------------------------------------------------------------
module lodc_ctrl import lodc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_EDGE = 5'b00100,
    S_WALK = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd            = '0;
    cmd.fault_code = ST_OK;
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_FIN;
        if (stat.frozen || !stat.in_range) begin
          // no change, just report
        end else if (stat.op == OP_RELEASE) begin
          if (stat.empty) begin
            cmd.set_fault  = 1'b1;
            cmd.fault_code = ST_MULTI_UNLOCK;
          end else if (stat.top_match) begin
            cmd.pop = 1'b1;
          end else begin
            cmd.set_fault  = 1'b1;
            cmd.fault_code = ST_INVALID_UNLOCK;
          end
        end else if (stat.full) begin
          cmd.set_fault  = 1'b1;
          cmd.fault_code = ST_STACK_FULL;
        end else if (stat.empty || stat.top_match) begin
          cmd.push = 1'b1;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (stat.edge_known) begin
          cmd.push  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.edge_set  = 1'b1;
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        cmd.row_walk = 1'b1;
        if (stat.found) begin
          cmd.set_fault  = 1'b1;
          cmd.fault_code = ST_DEADLOCK;
          state_nxt      = S_FIN;
        end else if (stat.pass_done) begin
          if (stat.changed) begin
            cmd.walk_pass = 1'b1;
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          cmd.walk_run = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ----- sv/lock_order_deadlock_checker_unit.sv -----
`timescale 1ns / 1ps
// Lock-order deadlock checker. Each request word names an acquire or a
// release of one lock; each request gives exactly one result word with the
// sticky status (ok, multiple unlock, invalid unlock, deadlock, stack full)
// and the number of held locks afterwards. Once any error is reported the
// block keeps reporting it, without changing state, until reset. Requests are
// handled one at a time. A release, a re-acquire of the top lock, an acquire
// on an empty stack and any request after an error go from the check state
// straight to the result; an acquire whose order edge is already known
// passes through the edge state first. An acquire that records a new edge
// starts a reachability search over the edge matrix, one matrix row read per
// cycle, in passes that repeat until nothing new is reached or the previous
// top lock is hit. The edge matrix comes out of reset empty through per-row
// valid bits, so no clearing pass is needed. Lock ids at or above LOCK_COUNT
// are ignored and report the current status and count.
// ----------------------------------------------------------------------------
// lock_order_deadlock_checker_unit
// Top level: sequencer plus datapath, request and result channels.
// ----------------------------------------------------------------------------
module lock_order_deadlock_checker_unit import lodc_pkg::*; #(
  parameter int LOCK_COUNT  = LOCK_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lodc_in_if.sink     in_chan,
  lodc_out_if.source  out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the handshakes and the per-request flow
  lodc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: held stack, order matrix, search state, result register
  lodc_datapath #(
    .LOCK_COUNT  (LOCK_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_chan.operation),
    .in_lock_id     (in_chan.lock_id),
    .cmd            (cmd),
    .stat           (stat),
    .res_status     (out_chan.status),
    .res_held_count (out_chan.held_count)
  );

endmodule
